/* sv/qtc_pkg.sv */
// Shared types, opcodes and tables for the quaternion transform chain unit.
// No dependencies; imported by qtc_ctrl, qtc_rd, qtc_dp and the top level.
package qtc_pkg;

	// fixed-point widths
	localparam int AW   = 40;  // A operand / term accumulators
	localparam int BW   = 34;  // B operand
	localparam int MW   = 22;  // multiplier A slice
	localparam int PW   = 56;  // partial product
	localparam int FW   = 74;  // full product
	localparam int SW   = 66;  // sum of squares
	localparam int SATW = 42;  // input of the 32-bit saturator

	localparam logic signed [31:0]   QONE     = 32'sh4000_0000;
	localparam logic signed [FW-1:0] RND_HALF = 74'sd536870912;

	// multiply phases
	localparam logic [1:0] PH_LO  = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_ACC = 2'd2;

	// datapath register-transfer opcodes
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_SQ     = 4'd1;
	localparam logic [3:0] OP_IDENT  = 4'd2;
	localparam logic [3:0] OP_DIV_WR = 4'd3;
	localparam logic [3:0] OP_I0     = 4'd4;
	localparam logic [3:0] OP_I1     = 4'd5;
	localparam logic [3:0] OP_I_FIN  = 4'd6;
	localparam logic [3:0] OP_C0     = 4'd7;
	localparam logic [3:0] OP_C1     = 4'd8;
	localparam logic [3:0] OP_C_T    = 4'd9;
	localparam logic [3:0] OP_C2     = 4'd10;
	localparam logic [3:0] OP_C_Q    = 4'd11;
	localparam logic [3:0] OP_FIRST  = 4'd12;
	localparam logic [3:0] OP_EMIT   = 4'd13;

	// Hamilton product term table, term = 4*out_part + k
	localparam logic [1:0] HAM_IA [16] = '{
		2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2,
		2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] HAM_IB [16] = '{
		2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
	localparam logic HAM_NEG [16] = '{
		1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

	typedef struct packed {
		logic sqrt_load;
		logic sqrt_step;
		logic sqrt_fix;
		logic div_load;
		logic div_step;
	} rd_cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       mac_en;
		logic       mac_sq;
		logic [1:0] phase;
		logic [3:0] term;
		logic [1:0] part;
		rd_cmd_t    rd;
	} dp_cmd_t;

	typedef struct packed {
		logic eq_zero;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[SATW-1:31];
		hi_zeros = ~|x[SATW-1:31];
		if (hi_ones || hi_zeros)
			return x[31:0];
		else if (x[SATW-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

/* sv/qtc_ctrl.sv */
// Sequencer for the quaternion transform chain unit.
// Depends on qtc_pkg; drives qtc_dp through dp_cmd_t, reads dp_sts_t.
module qtc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             edge_valid,
	output logic             edge_stall,
	input  logic             action,
	input  logic             first,
	input  logic             last,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             load,
	output qtc_pkg::dp_cmd_t cmd,
	input  qtc_pkg::dp_sts_t sts
);
	import qtc_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SQ_SET = 5'd1;
	localparam logic [4:0] S_SQ     = 5'd2;
	localparam logic [4:0] S_ZCHK   = 5'd3;
	localparam logic [4:0] S_RT_LD  = 5'd4;
	localparam logic [4:0] S_RT     = 5'd5;
	localparam logic [4:0] S_RT_FIX = 5'd6;
	localparam logic [4:0] S_DV_LD  = 5'd7;
	localparam logic [4:0] S_DV     = 5'd8;
	localparam logic [4:0] S_DV_WR  = 5'd9;
	localparam logic [4:0] S_I0     = 5'd10;
	localparam logic [4:0] S_I1     = 5'd11;
	localparam logic [4:0] S_I_FIN  = 5'd12;
	localparam logic [4:0] S_BR     = 5'd13;
	localparam logic [4:0] S_C0     = 5'd14;
	localparam logic [4:0] S_C1     = 5'd15;
	localparam logic [4:0] S_C_T    = 5'd16;
	localparam logic [4:0] S_C2     = 5'd17;
	localparam logic [4:0] S_C_Q    = 5'd18;
	localparam logic [4:0] S_FIRST  = 5'd19;
	localparam logic [4:0] S_HM     = 5'd20;
	localparam logic [4:0] S_EMIT   = 5'd21;

	logic [4:0] state_q, state_d, ret_q, ret_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] ph_q, ph_d, part_q, part_d;
	logic       first_q, last_q;
	logic       res_valid_q, emit;

	assign edge_stall = (state_q != S_IDLE);
	assign load       = edge_valid && (state_q == S_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cnt_d   = cnt_q;
		ph_d    = ph_q;
		part_d  = part_q;
		emit    = 1'b0;
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.term  = cnt_q[3:0];
		cmd.phase = ph_q;
		cmd.part  = part_q;
		unique case (state_q)
			S_IDLE: begin
				if (edge_valid)
					state_d = action ? S_SQ_SET : S_BR;
			end
			S_SQ_SET: begin
				cmd.op  = OP_SQ;
				cnt_d   = '0;
				ph_d    = PH_LO;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.mac_en = 1'b1;
				cmd.mac_sq = 1'b1;
				if (ph_q == PH_ACC) begin
					ph_d  = PH_LO;
					cnt_d = cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3)
						state_d = S_ZCHK;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			S_ZCHK: begin
				if (sts.eq_zero) begin
					cmd.op  = OP_IDENT;
					state_d = S_I0;
				end else begin
					state_d = S_RT_LD;
				end
			end
			S_RT_LD: begin
				cmd.rd.sqrt_load = 1'b1;
				cnt_d   = '0;
				state_d = S_RT;
			end
			S_RT: begin
				cmd.rd.sqrt_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = S_RT_FIX;
			end
			S_RT_FIX: begin
				cmd.rd.sqrt_fix = 1'b1;
				part_d  = '0;
				state_d = S_DV_LD;
			end
			S_DV_LD: begin
				cmd.rd.div_load = 1'b1;
				cnt_d   = '0;
				state_d = S_DV;
			end
			S_DV: begin
				cmd.rd.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = S_DV_WR;
			end
			S_DV_WR: begin
				cmd.op = OP_DIV_WR;
				part_d = part_q + 2'd1;
				state_d = (part_q == 2'd3) ? S_I0 : S_DV_LD;
			end
			S_I0: begin
				cmd.op = OP_I0;
				ret_d  = S_I1;
				cnt_d  = '0;
				ph_d   = PH_LO;
				state_d = S_HM;
			end
			S_I1: begin
				cmd.op = OP_I1;
				ret_d  = S_I_FIN;
				cnt_d  = '0;
				ph_d   = PH_LO;
				state_d = S_HM;
			end
			S_I_FIN: begin
				cmd.op  = OP_I_FIN;
				state_d = S_BR;
			end
			S_BR: begin
				state_d = first_q ? S_FIRST : S_C0;
			end
			S_C0: begin
				cmd.op = OP_C0;
				ret_d  = S_C1;
				cnt_d  = '0;
				ph_d   = PH_LO;
				state_d = S_HM;
			end
			S_C1: begin
				cmd.op = OP_C1;
				ret_d  = S_C_T;
				cnt_d  = '0;
				ph_d   = PH_LO;
				state_d = S_HM;
			end
			S_C_T: begin
				cmd.op  = OP_C_T;
				state_d = S_C2;
			end
			S_C2: begin
				cmd.op = OP_C2;
				ret_d  = S_C_Q;
				cnt_d  = '0;
				ph_d   = PH_LO;
				state_d = S_HM;
			end
			S_C_Q: begin
				cmd.op  = OP_C_Q;
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_FIRST: begin
				cmd.op  = OP_FIRST;
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_HM: begin
				cmd.mac_en = 1'b1;
				if (ph_q == PH_ACC) begin
					ph_d  = PH_LO;
					cnt_d = cnt_q + 5'd1;
					if (cnt_q[3:0] == 4'd15)
						state_d = ret_q;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			S_EMIT: begin
				if (!res_valid_q || !res_stall) begin
					cmd.op  = OP_EMIT;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			ph_q        <= PH_LO;
			part_q      <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			cnt_q   <= cnt_d;
			ph_q    <= ph_d;
			part_q  <= part_d;
			if (load) begin
				first_q <= first;
				last_q  <= last;
			end
			if (emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/qtc_rd.sv */
// Bit-serial square root and restoring divider for quaternion inversion.
// Depends on qtc_pkg; instantiated by qtc_dp.
module qtc_rd (
	input  logic              clk,
	input  qtc_pkg::rd_cmd_t  cmd,
	input  logic [64:0]       sum,
	input  logic [31:0]       mag,
	output logic [31:0]       quo
);
	import qtc_pkg::*;

	logic [63:0] s_q, r_q, bit_q, trial;
	logic        ovf_q, s_ge;
	logic [32:0] n_q, rem_q;
	logic [31:0] low_q;
	logic [62:0] dvd;
	logic [33:0] tdiv, diff;
	logic        ge;

	assign trial = r_q + bit_q;
	assign s_ge  = (s_q >= trial);
	assign dvd   = {1'b0, mag, 30'b0} + 63'(n_q >> 1);
	assign tdiv  = {rem_q, low_q[31]};
	assign ge    = (tdiv >= {1'b0, n_q});
	assign diff  = tdiv - {1'b0, n_q};
	assign quo   = low_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			s_q   <= sum[63:0];
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
			ovf_q <= sum[64];
		end
		if (cmd.sqrt_step) begin
			if (s_ge) begin
				s_q <= s_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		// round to nearest; a sum of 2^64 or more pins the norm at 2^32
		if (cmd.sqrt_fix) begin
			if (ovf_q)
				n_q <= 33'h1_0000_0000;
			else if (s_q > r_q)
				n_q <= r_q[32:0] + 33'd1;
			else
				n_q <= r_q[32:0];
		end
		if (cmd.div_load) begin
			rem_q <= {2'b0, dvd[62:32]};
			low_q <= dvd[31:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[32:0] : tdiv[32:0];
			low_q <= {low_q[30:0], ge};
		end
	end

endmodule

/* sv/qtc_dp.sv */
// Datapath: edge and accumulator registers, shared multiplier with term
// accumulation, and the root/divide unit. Depends on qtc_pkg and qtc_rd.
module qtc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  qtc_pkg::dp_cmd_t    cmd,
	output qtc_pkg::dp_sts_t    sts,
	input  logic                load,
	input  logic signed [31:0]  edge_tx,
	input  logic signed [31:0]  edge_ty,
	input  logic signed [31:0]  edge_tz,
	input  logic signed [31:0]  edge_qx,
	input  logic signed [31:0]  edge_qy,
	input  logic signed [31:0]  edge_qz,
	input  logic signed [31:0]  edge_qw,
	input  logic [47:0]         edge_time,
	output logic signed [31:0]  out_tx,
	output logic signed [31:0]  out_ty,
	output logic signed [31:0]  out_tz,
	output logic signed [31:0]  out_qx,
	output logic signed [31:0]  out_qy,
	output logic signed [31:0]  out_qz,
	output logic signed [31:0]  out_qw,
	output logic [47:0]         out_time
);
	import qtc_pkg::*;

	logic signed [31:0]   et_q [3];
	logic signed [31:0]   eq_q [4];
	logic signed [31:0]   acc_t_q [3];
	logic signed [31:0]   acc_r_q [4];
	logic [47:0]          etime_q, acc_time_q;
	logic signed [31:0]   o_t_q [3];
	logic signed [31:0]   o_r_q [4];
	logic [47:0]          o_time_q;

	logic signed [AW-1:0] a_q [4];
	logic signed [BW-1:0] b_q [4];
	logic signed [AW-1:0] r_q [4];
	logic signed [PW-1:0] lo_q, hi_q;
	logic [SW-1:0]        sum_q;

	logic [1:0]           ia, ib;
	logic                 neg;
	logic signed [AW-1:0] mac_a;
	logic signed [BW-1:0] mac_b;
	logic signed [MW-1:0] mul_x;
	logic signed [PW-1:0] prod;
	logic signed [FW-1:0] full, biased, shifted;
	logic signed [AW-1:0] term_v;

	logic [31:0]          rd_quo, mag;
	logic signed [31:0]   eq_p;
	logic                 q_neg;

	qtc_rd u_rd (
		.clk (clk),
		.cmd (cmd.rd),
		.sum (sum_q[64:0]),
		.mag (mag),
		.quo (rd_quo)
	);

	// one product per term: low slice, high slice, then accumulate (rounded, except for squares)
	always_comb begin
		ia     = cmd.mac_sq ? cmd.term[1:0] : HAM_IA[cmd.term];
		ib     = cmd.mac_sq ? cmd.term[1:0] : HAM_IB[cmd.term];
		neg    = !cmd.mac_sq && HAM_NEG[cmd.term];
		mac_a  = a_q[ia];
		mac_b  = b_q[ib];
		mul_x  = (cmd.phase == PH_LO) ? $signed({4'b0, mac_a[17:0]}) : mac_a[AW-1:18];
		prod   = mul_x * mac_b;
		full   = {{(FW-PW){lo_q[PW-1]}}, lo_q} + ({{(FW-PW){hi_q[PW-1]}}, hi_q} << 18);
		biased = full + RND_HALF;
		shifted = biased >>> 30;
		term_v = shifted[AW-1:0];
	end

	always_comb begin
		eq_p  = eq_q[cmd.part];
		mag   = eq_p[31] ? 32'(-eq_p) : eq_p;
		q_neg = eq_p[31] ^ (cmd.part != 2'd3);
	end

	assign sts.eq_zero = (eq_q[0] == 32'sd0) && (eq_q[1] == 32'sd0) &&
		(eq_q[2] == 32'sd0) && (eq_q[3] == 32'sd0);

	// operand, product and edge registers
	always_ff @(posedge clk) begin
		if (load) begin
			et_q[0] <= edge_tx;
			et_q[1] <= edge_ty;
			et_q[2] <= edge_tz;
			eq_q[0] <= edge_qx;
			eq_q[1] <= edge_qy;
			eq_q[2] <= edge_qz;
			eq_q[3] <= edge_qw;
			etime_q <= edge_time;
		end
		if (cmd.mac_en) begin
			case (cmd.phase)
				PH_LO:  lo_q <= prod;
				PH_HI:  hi_q <= prod;
				default: begin
					if (cmd.mac_sq)
						sum_q <= sum_q + full[SW-1:0];
					else
						r_q[cmd.term[3:2]] <= r_q[cmd.term[3:2]] + (neg ? -term_v : term_v);
				end
			endcase
		end
		case (cmd.op)
			OP_SQ: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= AW'(eq_q[k]);
					b_q[k] <= BW'(eq_q[k]);
				end
				sum_q <= '0;
			end
			OP_IDENT: begin
				eq_q[0] <= 32'sd0;
				eq_q[1] <= 32'sd0;
				eq_q[2] <= 32'sd0;
				eq_q[3] <= QONE;
			end
			OP_DIV_WR: begin
				eq_q[cmd.part] <= q_neg ? -$signed(rd_quo) : $signed(rd_quo);
			end
			OP_I0: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= AW'(eq_q[k]);
					r_q[k] <= '0;
				end
				for (int k = 0; k < 3; k++)
					b_q[k] <= BW'(et_q[k]);
				b_q[3] <= '0;
			end
			OP_I1: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= r_q[k];
					r_q[k] <= '0;
				end
				for (int k = 0; k < 3; k++)
					b_q[k] <= -BW'(eq_q[k]);
				b_q[3] <= BW'(eq_q[3]);
			end
			OP_I_FIN: begin
				for (int k = 0; k < 3; k++)
					et_q[k] <= sat32(-SATW'(r_q[k]));
			end
			OP_C0: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= AW'(acc_r_q[k]);
					r_q[k] <= '0;
				end
				for (int k = 0; k < 3; k++)
					b_q[k] <= BW'(et_q[k]);
				b_q[3] <= '0;
			end
			OP_C1: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= r_q[k];
					r_q[k] <= '0;
				end
				for (int k = 0; k < 3; k++)
					b_q[k] <= -BW'(acc_r_q[k]);
				b_q[3] <= BW'(acc_r_q[3]);
			end
			OP_C2: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= AW'(acc_r_q[k]);
					b_q[k] <= BW'(eq_q[k]);
					r_q[k] <= '0;
				end
			end
			OP_EMIT: begin
				o_t_q    <= acc_t_q;
				o_r_q    <= acc_r_q;
				o_time_q <= acc_time_q;
			end
			default: ;
		endcase
	end

	// running transform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				acc_t_q[k] <= 32'sd0;
			acc_r_q[0] <= 32'sd0;
			acc_r_q[1] <= 32'sd0;
			acc_r_q[2] <= 32'sd0;
			acc_r_q[3] <= QONE;
			acc_time_q <= '0;
		end else begin
			case (cmd.op)
				OP_FIRST: begin
					acc_t_q    <= et_q;
					acc_r_q    <= eq_q;
					acc_time_q <= etime_q;
				end
				OP_C_T: begin
					for (int k = 0; k < 3; k++)
						acc_t_q[k] <= sat32(SATW'(acc_t_q[k]) + SATW'(r_q[k]));
					if (etime_q > acc_time_q)
						acc_time_q <= etime_q;
				end
				OP_C_Q: begin
					for (int k = 0; k < 4; k++)
						acc_r_q[k] <= sat32(SATW'(r_q[k]));
				end
				default: ;
			endcase
		end
	end

	assign out_tx   = o_t_q[0];
	assign out_ty   = o_t_q[1];
	assign out_tz   = o_t_q[2];
	assign out_qx   = o_r_q[0];
	assign out_qy   = o_r_q[1];
	assign out_qz   = o_r_q[2];
	assign out_qw   = o_r_q[3];
	assign out_time = o_time_q;

endmodule

/* sv/quaternion_transform_chain_unit.sv */
// Top level of the quaternion transform chain unit.
// Depends on qtc_pkg, qtc_ctrl and qtc_dp (which holds qtc_rd).
//
// Usage:
//  - Edge channel (edge_valid/edge_stall): one transaction carries one rigid
//    transform edge (Q16.16 translation, Q2.30 quaternion, timestamp) plus
//    action (invert first), first (restart chain) and last (emit result).
//  - Result channel (res_valid/res_stall): one transaction per edge marked
//    last, holding the running transform after that edge.
//  - One edge at a time. edge_stall is low only while the sequencer idles.
//    Work per edge, paced by the single shared 22x34 multiplier (each rounded
//    product: low slice, high slice, then round and accumulate):
//      first, no invert:      loads the edge as the running transform
//      compose, no invert:    three quaternion products
//      invert adds:           squares, 32-step root, four
//                             32-step divides, two quaternion products
//      all-zero quaternion inverted: skips root and divides.
//      an edge marked last adds an emit step.
//  - Result registers part the two sides: the next edge is taken while a
//    result waits; an edge marked last waits in its emit step until the
//    previous result has been taken.
//  - Reset (arst_n low) clears the running transform to the identity with
//    zero translation and time, and drops any pending result.
module quaternion_transform_chain_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               edge_valid,
	output logic               edge_stall,
	input  logic               action,
	input  logic               first,
	input  logic signed [31:0] edge_tx,
	input  logic signed [31:0] edge_ty,
	input  logic signed [31:0] edge_tz,
	input  logic signed [31:0] edge_qx,
	input  logic signed [31:0] edge_qy,
	input  logic signed [31:0] edge_qz,
	input  logic signed [31:0] edge_qw,
	input  logic [47:0]        edge_time,
	input  logic               last,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] out_tx,
	output logic signed [31:0] out_ty,
	output logic signed [31:0] out_tz,
	output logic signed [31:0] out_qx,
	output logic signed [31:0] out_qy,
	output logic signed [31:0] out_qz,
	output logic signed [31:0] out_qw,
	output logic [47:0]        out_time
);
	import qtc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    load;

	// sequencer: walks squares, root, divides and the quaternion
	// products, one command per cycle
	qtc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.edge_stall (edge_stall),
		.action     (action),
		.first      (first),
		.last       (last),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.load       (load),
		.cmd        (cmd),
		.sts        (sts)
	);

	// datapath: edge capture, accumulator, shared multiplier, root/divider
	qtc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.load      (load),
		.edge_tx   (edge_tx),
		.edge_ty   (edge_ty),
		.edge_tz   (edge_tz),
		.edge_qx   (edge_qx),
		.edge_qy   (edge_qy),
		.edge_qz   (edge_qz),
		.edge_qw   (edge_qw),
		.edge_time (edge_time),
		.out_tx    (out_tx),
		.out_ty    (out_ty),
		.out_tz    (out_tz),
		.out_qx    (out_qx),
		.out_qy    (out_qy),
		.out_qz    (out_qz),
		.out_qw    (out_qw),
		.out_time  (out_time)
	);

endmodule
